[sv/dst_pkg.sv]
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the deadline sorted table
// Field widths, operation and status codes, control state, and the control
// group broadcast from the top level to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

   // Field widths of one beat
   localparam int OP_W        = 2;
   localparam int POS_W       = 7;
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int TAG_PORT_W  = 16;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 8;

   // Sort key: year, then month, then day
   localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;

   // Stream widths (whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - (STATUS_W + COUNT_OUT_W + POS_W + KEY_W
                                             + TAG_PORT_W);

   // Defaults of the top level parameters
   localparam int DEF_TABLE_DEPTH = 128;
   localparam int DEF_TAG_BITS    = 16;

   // Cells per group in the result collection tree
   localparam int GROUP_SIZE = 16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_EDIT   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_ZERO_DATE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXEC   = 2'd1,
      S_GATHER = 2'd2,
      S_DONE   = 2'd3
   } state_type;

   // Broadcast to every cell during the execute cycle
   typedef struct packed {
      logic             active;     // execute cycle
      logic             shift_en;   // close the gap at the position
      logic             insert_en;  // place the new entry in order
      logic             read_en;    // flag the cell at the position
      logic [KEY_W-1:0] key;        // date key of the new entry
   } cell_ctrl_type;

endpackage

`default_nettype wire

[sv/deadline_sorted_table.sv]
// ----------------------------------------------------------------------------
// deadline_sorted_table: bounded table of entries kept in deadline order
// Usage:
//   req_ carries one operation per beat: insert, remove at a position, edit
//   at a position (remove, then reinsert with a new date and tag), or read
//   at a position. Positions are 0-based. rsp_ returns exactly one beat per
//   request with a status, the entry count after the operation, the landing
//   position of an inserted or edited entry and the entry read.
//   Entries sit in a row of cells, one per position. Every cell compares its
//   entry with the new date and shifts with its neighbors in the execute cycle, so
//   an operation costs the same whatever the fill.
//   From the accepted request beat to the response beat being presented, a
//   request passes the execute cycle in the cell row, the registered
//   collection tree that brings the result out of the row, and the output
//   register, in that order.
//   A new request is taken only once the previous one has reached the output
//   register; req_tready is high while no request is in flight.
//   A stalled response waits in the output register while the next request
//   is already taken and executed; that request's result holds in the
//   collection tree until the output register is free.
//   Reset: synchronous, active high; the table comes up empty and no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_sorted_table #(
   parameter int TABLE_DEPTH = dst_pkg::DEF_TABLE_DEPTH,
   parameter int TAG_BITS    = dst_pkg::DEF_TAG_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // operation, position, due_day, due_month, due_year, entry_tag
   input  wire logic [dst_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // status, entry_count, placed_at, read_day, read_month, read_year,
   // read_tag, zero pad
   output logic [dst_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WIDE_W = (CNT_W > dst_pkg::POS_W) ? CNT_W : dst_pkg::POS_W;
   localparam int LANE_W = dst_pkg::POS_W + dst_pkg::KEY_W + TAG_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   dst_pkg::state_type state_ff, state_in;

   // Request register
   dst_pkg::op_type                  op_ff;
   logic [dst_pkg::POS_W-1:0]        pos_ff;
   logic [dst_pkg::DAY_W-1:0]        day_ff;
   logic [dst_pkg::MONTH_W-1:0]      month_ff;
   logic [dst_pkg::YEAR_W-1:0]       year_ff;
   logic [dst_pkg::TAG_PORT_W-1:0]   tag_ff;

   logic [CNT_W-1:0]                 count_ff, count_in;
   dst_pkg::status_type              status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dst_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                             accept, load_rsp;
   logic                             pos_ok, zero_date;
   logic [WIDE_W-1:0]                pos_wide, count_wide;
   dst_pkg::cell_ctrl_type           ctrl;
   logic [CNT_W-1:0]                 count_base;
   logic [CNT_W-1:0]                 pos_cell;
   logic [TAG_BITS-1:0]              new_tag;

   // Cell row wiring
   logic [dst_pkg::KEY_W-1:0]        cur_key [TABLE_DEPTH];
   logic [TAG_BITS-1:0]              cur_tag [TABLE_DEPTH];
   logic [dst_pkg::KEY_W-1:0]        sh_key  [TABLE_DEPTH];
   logic [TAG_BITS-1:0]              sh_tag  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]           lt_vec;
   logic [TABLE_DEPTH-1:0]           place_vec;
   logic [TABLE_DEPTH-1:0][LANE_W-1:0] lanes;
   logic [LANE_W-1:0]                merged;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == dst_pkg::S_IDLE) && !reset;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= dst_pkg::op_type'(req_tdata[1:0]);
         pos_ff   <= req_tdata[8:2];
         day_ff   <= req_tdata[13:9];
         month_ff <= req_tdata[17:14];
         year_ff  <= req_tdata[31:18];
         tag_ff   <= req_tdata[47:32];
      end
   end

   // Check the operation against the table
   assign pos_wide   = WIDE_W'(pos_ff);
   assign count_wide = WIDE_W'(count_ff);
   assign pos_ok     = pos_wide < count_wide;
   assign zero_date  = (day_ff == '0) || (month_ff == '0) || (year_ff == '0);

   always_comb begin
      status_in = dst_pkg::STAT_OK;
      if (op_ff == dst_pkg::OP_INSERT) begin
         if (count_ff == FULL_COUNT) begin
            status_in = dst_pkg::STAT_FULL;
         end else if (zero_date) begin
            status_in = dst_pkg::STAT_ZERO_DATE;
         end
      end else if (count_ff == '0) begin
         status_in = dst_pkg::STAT_EMPTY;
      end else if (!pos_ok) begin
         status_in = dst_pkg::STAT_BAD_POS;
      end
   end

   // Broadcast control to the cell row
   always_comb begin
      ctrl           = '0;
      ctrl.active    = (state_ff == dst_pkg::S_EXEC);
      ctrl.key       = {year_ff, month_ff, day_ff};
      if (ctrl.active && (status_in == dst_pkg::STAT_OK)) begin
         unique case (op_ff)
            dst_pkg::OP_INSERT: ctrl.insert_en = 1'b1;
            dst_pkg::OP_REMOVE: ctrl.shift_en  = 1'b1;
            dst_pkg::OP_EDIT: begin
               ctrl.shift_en  = 1'b1;
               ctrl.insert_en = 1'b1;
            end
            dst_pkg::OP_READ:   ctrl.read_en   = 1'b1;
            default: ;
         endcase
      end
   end

   assign count_base = ctrl.shift_en ? (count_ff - CNT_W'(1)) : count_ff;
   assign pos_cell   = CNT_W'(pos_wide);
   assign new_tag    = TAG_BITS'(tag_ff);

   // Count after the operation
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_base + CNT_W'(1);
      end else if (ctrl.shift_en) begin
         count_in = count_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.active) begin
         status_ff <= status_in;
      end
   end

   // Row of storage cells
   for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
      logic [dst_pkg::KEY_W-1:0] nb_next_key, nb_prev_key;
      logic [TAG_BITS-1:0]       nb_next_tag, nb_prev_tag;
      logic                      nb_prev_lt;

      if (j == TABLE_DEPTH - 1) begin : g_last
         assign nb_next_key = cur_key[j];
         assign nb_next_tag = cur_tag[j];
      end else begin : g_mid
         assign nb_next_key = cur_key[j + 1];
         assign nb_next_tag = cur_tag[j + 1];
      end

      if (j == 0) begin : g_first
         assign nb_prev_key = sh_key[j];
         assign nb_prev_tag = sh_tag[j];
         assign nb_prev_lt  = 1'b0;
      end else begin : g_rest
         assign nb_prev_key = sh_key[j - 1];
         assign nb_prev_tag = sh_tag[j - 1];
         assign nb_prev_lt  = lt_vec[j - 1];
      end

      dst_cell #(
         .TAG_BITS   (TAG_BITS),
         .CNT_W      (CNT_W),
         .CELL_INDEX (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count_base (count_base),
         .pos        (pos_cell),
         .new_tag    (new_tag),
         .next_key   (nb_next_key),
         .next_tag   (nb_next_tag),
         .prev_key   (nb_prev_key),
         .prev_tag   (nb_prev_tag),
         .prev_lt    (nb_prev_lt),
         .cur_key    (cur_key[j]),
         .cur_tag    (cur_tag[j]),
         .sh_key     (sh_key[j]),
         .sh_tag     (sh_tag[j]),
         .lt         (lt_vec[j]),
         .place_hit  (place_vec[j]),
         .lane       (lanes[j])
      );
   end

   // Bring the flagged result out of the row
   dst_gather #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (LANE_W)
   ) u_gather (
      .clock  (clock),
      .lanes  (lanes),
      .merged (merged)
   );

   // Sequence one operation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         dst_pkg::S_IDLE: begin
            if (accept) begin
               state_in = dst_pkg::S_EXEC;
            end
         end
         dst_pkg::S_EXEC:   state_in = dst_pkg::S_GATHER;
         dst_pkg::S_GATHER: state_in = dst_pkg::S_DONE;
         dst_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = dst_pkg::S_IDLE;
            end
         end
         default: state_in = dst_pkg::S_IDLE;
      endcase
   end

   // Pack the response beat
   always_comb begin
      logic [dst_pkg::KEY_W-1:0] rd_key;
      logic [TAG_BITS-1:0]       rd_tag;
      rd_key = merged[TAG_BITS +: dst_pkg::KEY_W];
      rd_tag = merged[TAG_BITS-1:0];
      rsp_data_in = {
         {dst_pkg::RSP_PAD_W{1'b0}},
         dst_pkg::TAG_PORT_W'(rd_tag),
         rd_key,
         merged[LANE_W-1 -: dst_pkg::POS_W],
         dst_pkg::COUNT_OUT_W'(count_ff),
         status_ff
      };
   end

   // Output register
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_one_place: assert property (@(posedge clock) disable iff (reset)
      $onehot0(place_vec))
      else $error("more than one cell took the new entry");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dst_pkg::S_EXEC) |=> (count_ff == $past(count_ff)))
      else $error("entry count moved outside the execute cycle");

   a_place_ok: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dst_pkg::S_GATHER) && (place_vec != '0)) |->
         (status_ff == dst_pkg::STAT_OK))
      else $error("entry placed by a failed operation");

endmodule

`default_nettype wire

[sv/dst_cell.sv]
// ----------------------------------------------------------------------------
// dst_cell: one storage cell of the sorted table
// Holds one entry, compares it with the broadcast key, and takes its next
// value from itself, its left neighbor, its right neighbor or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_cell #(
   parameter int TAG_BITS   = dst_pkg::DEF_TAG_BITS,
   parameter int CNT_W      = 8,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dst_pkg::cell_ctrl_type                 ctrl,
   input  wire logic [CNT_W-1:0]                       count_base,
   input  wire logic [CNT_W-1:0]                       pos,
   input  wire logic [TAG_BITS-1:0]                    new_tag,
   // right neighbor's stored entry
   input  wire logic [dst_pkg::KEY_W-1:0]              next_key,
   input  wire logic [TAG_BITS-1:0]                    next_tag,
   // left neighbor's entry after gap closing, and its compare flag
   input  wire logic [dst_pkg::KEY_W-1:0]              prev_key,
   input  wire logic [TAG_BITS-1:0]                    prev_tag,
   input  wire logic                                   prev_lt,
   output logic [dst_pkg::KEY_W-1:0]                   cur_key,
   output logic [TAG_BITS-1:0]                         cur_tag,
   output logic [dst_pkg::KEY_W-1:0]                   sh_key,
   output logic [TAG_BITS-1:0]                         sh_tag,
   output logic                                        lt,
   output logic                                        place_hit,
   // placed index, key, tag (high to low), zero unless flagged
   output logic [dst_pkg::POS_W+dst_pkg::KEY_W+TAG_BITS-1:0] lane
);

   localparam logic [CNT_W-1:0]          MY_IDX = CNT_W'(CELL_INDEX);
   localparam logic [dst_pkg::POS_W-1:0] MY_POS = dst_pkg::POS_W'(CELL_INDEX);

   logic [dst_pkg::KEY_W-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0]       tag_ff, tag_in;
   logic                      place_hit_ff, place_hit_in;
   logic                      read_hit_ff, read_hit_in;
   logic                      here;

   assign cur_key = key_ff;
   assign cur_tag = tag_ff;

   // Close the gap: cells at and beyond the position take the right neighbor
   always_comb begin
      if (ctrl.shift_en && (MY_IDX >= pos)) begin
         sh_key = next_key;
         sh_tag = next_tag;
      end else begin
         sh_key = key_ff;
         sh_tag = tag_ff;
      end
   end

   // New key sorts strictly before this entry
   assign lt   = (MY_IDX < count_base) && (ctrl.key < sh_key);
   assign here = (lt || (MY_IDX == count_base)) && !prev_lt;

   // Pick the next entry
   always_comb begin
      key_in       = sh_key;
      tag_in       = sh_tag;
      place_hit_in = 1'b0;
      read_hit_in  = ctrl.read_en && (MY_IDX == pos);
      if (ctrl.insert_en) begin
         if (here) begin
            key_in       = ctrl.key;
            tag_in       = new_tag;
            place_hit_in = 1'b1;
         end else if (prev_lt) begin
            key_in = prev_key;
            tag_in = prev_tag;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (ctrl.active) begin
         key_ff <= key_in;
         tag_ff <= tag_in;
      end
   end

   // Result flags, held until the next operation
   always_ff @(posedge clock) begin
      if (reset) begin
         place_hit_ff <= 1'b0;
         read_hit_ff  <= 1'b0;
      end else if (ctrl.active) begin
         place_hit_ff <= place_hit_in;
         read_hit_ff  <= read_hit_in;
      end
   end

   assign place_hit = place_hit_ff;
   assign lane = {({dst_pkg::POS_W{place_hit_ff}} & MY_POS),
                  ({(dst_pkg::KEY_W + TAG_BITS){read_hit_ff}} & {key_ff, tag_ff})};

endmodule

`default_nettype wire

[sv/dst_gather.sv]
// ----------------------------------------------------------------------------
// dst_gather: result collection across the cell row
// ORs the flagged lanes in registered groups, then merges the groups.
// At most one cell drives a nonzero lane in each field.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_gather #(
   parameter int DEPTH = dst_pkg::DEF_TABLE_DEPTH,
   parameter int WIDTH = 8
) (
   input  wire logic                         clock,
   input  wire logic [DEPTH-1:0][WIDTH-1:0]  lanes,
   output logic [WIDTH-1:0]                  merged
);

   localparam int GS = dst_pkg::GROUP_SIZE;
   localparam int NG = (DEPTH + GS - 1) / GS;

   logic [NG*GS-1:0][WIDTH-1:0] lane_pad;
   logic [NG-1:0][WIDTH-1:0]    group_ff, group_in;

   // Pad the row to whole groups
   for (genvar i = 0; i < NG * GS; i++) begin : g_pad
      if (i < DEPTH) begin : g_real
         assign lane_pad[i] = lanes[i];
      end else begin : g_zero
         assign lane_pad[i] = '0;
      end
   end

   // OR within each group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GS; k++) begin
            group_in[g] = group_in[g] | lane_pad[g * GS + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // Merge the groups
   always_comb begin
      merged = '0;
      for (int g = 0; g < NG; g++) begin
         merged = merged | group_ff[g];
      end
   end

endmodule

`default_nettype wire

[tb/sv/deadline_sorted_table_tb.sv]
// ----------------------------------------------------------------------------
// deadline_sorted_table_tb: self-checking bench for the deadline sorted table
// Streams insert, remove, edit and read requests into the table and checks
// every response beat against a software copy of the table kept in date
// order. Runs a directed opener, a fill to capacity under a long response
// hold-off, a long random mix with clustered dates, and a drain to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_sorted_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = dst_pkg::DEF_TABLE_DEPTH;
   localparam int MIX_ITEMS   = 1450;
   localparam int LONG_HOLD   = 400;
   localparam int END_CYCLES  = 40;
   localparam int CYCLE_LIMIT = 400000;

   // Request beat, packed so the last declared field, the operation, lands in the lowest bits
   typedef struct packed {
      logic [dst_pkg::TAG_PORT_W-1:0] tag;
      logic [dst_pkg::YEAR_W-1:0]     year;
      logic [dst_pkg::MONTH_W-1:0]    month;
      logic [dst_pkg::DAY_W-1:0]      day;
      logic [dst_pkg::POS_W-1:0]      pos;
      dst_pkg::op_type                op;
   } table_req_type;

   // Response beat, same packing
   typedef struct packed {
      logic [dst_pkg::RSP_PAD_W-1:0]   pad;
      logic [dst_pkg::TAG_PORT_W-1:0]  tag;
      logic [dst_pkg::YEAR_W-1:0]      year;
      logic [dst_pkg::MONTH_W-1:0]     month;
      logic [dst_pkg::DAY_W-1:0]       day;
      logic [dst_pkg::POS_W-1:0]       placed;
      logic [dst_pkg::COUNT_OUT_W-1:0] count;
      dst_pkg::status_type             status;
   } table_rsp_type;

   typedef struct packed {
      logic [dst_pkg::DAY_W-1:0]      day;
      logic [dst_pkg::MONTH_W-1:0]    month;
      logic [dst_pkg::YEAR_W-1:0]     year;
      logic [dst_pkg::TAG_PORT_W-1:0] tag;
   } sched_entry_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dst_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // operation, position, due_day,
                                                    // due_month, due_year, entry_tag
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dst_pkg::RSP_DATA_W-1:0] rsp_tdata;       // status, entry_count, placed_at,
                                                    // read_day, read_month, read_year,
                                                    // read_tag, zero pad

   // Software copy of the table
   sched_entry_type sched [DEPTH];
   int              sched_count = 0;
   int              peak_fill = 0;

   table_req_type   pending_ops[$];
   table_rsp_type   awaited_results[$];
   table_req_type   cur_item;
   table_rsp_type   got_rsp, want_rsp;

   int           fill_est = 0;        // fill as seen by the generator
   bit           idle_on = 1'b1;
   bit           long_hold_ask = 1'b0;
   int           gap_left = 0;
   int           rsp_stall_left = 0;
   int           hold_left = 0;
   int           mismatch_count = 0;
   int           accepted_count = 0;
   int           checked_count = 0;
   int           cycle_count = 0;
   int           status_seen [5];

   deadline_sorted_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------------

   // Close the gap at a position
   function automatic void drop_entry(int pos);
      int i;
      for (i = pos; i + 1 < sched_count; i++) sched[i] = sched[i + 1];
      sched_count--;
   endfunction

   // Place after every entry with an equal or earlier date
   function automatic int place_entry(table_req_type rq);
      int                         i;
      logic [dst_pkg::KEY_W-1:0]  new_key;
      new_key = {rq.year, rq.month, rq.day};
      i = sched_count;
      while (i > 0 && new_key < {sched[i-1].year, sched[i-1].month, sched[i-1].day}) begin
         sched[i] = sched[i-1];
         i--;
      end
      sched[i] = '{day: rq.day, month: rq.month, year: rq.year, tag: rq.tag};
      sched_count++;
      if (sched_count > peak_fill) peak_fill = sched_count;
      return i;
   endfunction

   function automatic table_rsp_type table_outcome(table_req_type rq);
      table_rsp_type rs;
      rs = '0;
      rs.status = dst_pkg::STAT_OK;
      if (rq.op == dst_pkg::OP_INSERT) begin
         if (sched_count >= DEPTH)
            rs.status = dst_pkg::STAT_FULL;
         else if (rq.day == 0 || rq.month == 0 || rq.year == 0)
            rs.status = dst_pkg::STAT_ZERO_DATE;
         else
            rs.placed = dst_pkg::POS_W'(place_entry(rq));
      end else if (sched_count == 0) begin
         rs.status = dst_pkg::STAT_EMPTY;
      end else if (int'(rq.pos) >= sched_count) begin
         rs.status = dst_pkg::STAT_BAD_POS;
      end else begin
         case (rq.op)
            dst_pkg::OP_REMOVE: drop_entry(rq.pos);
            dst_pkg::OP_EDIT: begin
               drop_entry(rq.pos);
               rs.placed = dst_pkg::POS_W'(place_entry(rq));
            end
            default: begin
               rs.day   = sched[rq.pos].day;
               rs.month = sched[rq.pos].month;
               rs.year  = sched[rq.pos].year;
               rs.tag   = sched[rq.pos].tag;
            end
         endcase
      end
      rs.count = dst_pkg::COUNT_OUT_W'(sched_count);
      return rs;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic table_req_type mk_req(dst_pkg::op_type op, int pos, int day,
                                            int month, int year, int tag);
      table_req_type rq;
      rq.op    = op;
      rq.pos   = pos[dst_pkg::POS_W-1:0];
      rq.day   = day[dst_pkg::DAY_W-1:0];
      rq.month = month[dst_pkg::MONTH_W-1:0];
      rq.year  = year[dst_pkg::YEAR_W-1:0];
      rq.tag   = tag[dst_pkg::TAG_PORT_W-1:0];
      return rq;
   endfunction

   // Mostly valid positions; dates mostly clustered so equal dates are common
   function automatic table_req_type random_item(dst_pkg::op_type op);
      table_req_type rq;
      int            sel;
      rq.op  = op;
      rq.tag = dst_pkg::TAG_PORT_W'($urandom_range(0, 65535));
      if (fill_est > 0 && $urandom_range(0, 9) < 8)
         rq.pos = dst_pkg::POS_W'($urandom_range(0, fill_est - 1));
      else
         rq.pos = dst_pkg::POS_W'($urandom_range(0, 127));
      sel = $urandom_range(0, 19);
      if (sel < 6) begin
         rq.day   = dst_pkg::DAY_W'($urandom_range(1, 31));
         rq.month = dst_pkg::MONTH_W'($urandom_range(1, 15));
         rq.year  = dst_pkg::YEAR_W'($urandom_range(1, 16383));
      end else begin
         rq.day   = dst_pkg::DAY_W'($urandom_range(1, 4));
         rq.month = dst_pkg::MONTH_W'($urandom_range(1, 3));
         rq.year  = dst_pkg::YEAR_W'($urandom_range(2020, 2023));
      end
      // Knock out one date field now and then
      if (sel == 0) begin
         case ($urandom_range(0, 2))
            0: rq.day = '0;
            1: rq.month = '0;
            default: rq.year = '0;
         endcase
      end
      return rq;
   endfunction

   // Queue a request and track the fill it leaves behind
   function automatic void queue_item(table_req_type rq);
      pending_ops.push_back(rq);
      case (rq.op)
         dst_pkg::OP_INSERT:
            if (fill_est < DEPTH && rq.day != 0 && rq.month != 0 && rq.year != 0) fill_est++;
         dst_pkg::OP_REMOVE:
            if (int'(rq.pos) < fill_est) fill_est--;
         default: ;
      endcase
   endfunction

   // Hold the sender until every queued request has its response
   task automatic wait_table_idle();
      while (!(pending_ops.size() == 0 && !req_tvalid && awaited_results.size() == 0))
         @(negedge clock);
   endtask

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: predict on each accepted beat, then load the next one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want_rsp = table_outcome(cur_item);
            awaited_results.push_back(want_rsp);
            status_seen[int'(want_rsp.status)]++;
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (idle_on && pending_ops.size() > 0 && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               cur_item = pending_ops.pop_front();
               req_tdata  <= cur_item;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response ready: long hold-off on request, short random stalls otherwise
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = table_rsp_type'(rsp_tdata);
         if (awaited_results.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatch_count++;
         end else begin
            want_rsp = awaited_results.pop_front();
            check_field("status",      want_rsp.status, got_rsp.status);
            check_field("entry_count", want_rsp.count,  got_rsp.count);
            check_field("placed_at",   want_rsp.placed, got_rsp.placed);
            check_field("read_day",    want_rsp.day,    got_rsp.day);
            check_field("read_month",  want_rsp.month,  got_rsp.month);
            check_field("read_year",   want_rsp.year,   got_rsp.year);
            check_field("read_tag",    want_rsp.tag,    got_rsp.tag);
            checked_count++;
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[deadline_sorted_table] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int              n;
      dst_pkg::op_type op;
      int              ins_w;

      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty table, zero date fields, extreme dates, equal dates, bad positions
      queue_item(mk_req(dst_pkg::OP_READ,   0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_EDIT,   0, 5, 5, 2024, 16'h0101));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 0, 6, 2024, 16'h0001));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 6, 0, 2024, 16'h0002));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 6, 6, 0, 16'h0003));
      queue_item(mk_req(dst_pkg::OP_INSERT, 127, 31, 15, 16383, 16'hFFFF));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 1, 1, 1, 16'h0000));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 1, 1, 1, 16'h5555));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 15, 7, 2024, 16'hAAAA));
      for (n = 0; n < 4; n++) queue_item(mk_req(dst_pkg::OP_READ, n, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_READ, 4, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_READ, 127, 0, 0, 0, 0));
      // Edit takes a date with zero fields
      queue_item(mk_req(dst_pkg::OP_EDIT, 0, 0, 0, 0, 16'h1234));
      queue_item(mk_req(dst_pkg::OP_EDIT, 3, 2, 1, 1, 16'h0F0F));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 4, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 3, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_READ, 0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_READ, 1, 0, 0, 0, 0));
      wait_table_idle();

      // Fill to capacity while the response side holds off for a long stretch
      long_hold_ask = 1'b1;
      n = 0;
      while (fill_est < DEPTH && n < 600) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_item(random_item(dst_pkg::op_type'($urandom_range(1, 3))));
         end else begin
            queue_item(random_item(dst_pkg::OP_INSERT));
         end
         n++;
      end
      queue_item(mk_req(dst_pkg::OP_READ, 127, 0, 0, 0, 0));
      for (n = 0; n < 6; n++) queue_item(random_item(dst_pkg::OP_INSERT));
      // Full is reported ahead of a zero date
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 0, 0, 0, 16'hBEEF));
      queue_item(random_item(dst_pkg::OP_EDIT));
      queue_item(mk_req(dst_pkg::OP_EDIT, 127, 31, 15, 16383, 16'hFFFF));
      queue_item(mk_req(dst_pkg::OP_READ, 127, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 127, 0, 0, 0, 0));
      queue_item(random_item(dst_pkg::OP_INSERT));
      queue_item(random_item(dst_pkg::OP_INSERT));
      wait_table_idle();

      // Random mix, steered so the fill wanders across the whole range
      for (n = 0; n < MIX_ITEMS; n++) begin
         ins_w = (fill_est < 32) ? 55 : ((fill_est > 112) ? 20 : 35);
         if ($urandom_range(0, 99) < ins_w) op = dst_pkg::OP_INSERT;
         else op = dst_pkg::op_type'($urandom_range(1, 3));
         queue_item(random_item(op));
      end
      wait_table_idle();

      // Drain to empty at full rate
      idle_on = 1'b0;
      n = 0;
      while (fill_est > 0 && n < 1000) begin
         if ($urandom_range(0, 4) == 0) queue_item(random_item(dst_pkg::OP_READ));
         else queue_item(random_item(dst_pkg::OP_REMOVE));
         n++;
      end
      queue_item(mk_req(dst_pkg::OP_READ, 0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_REMOVE, 0, 0, 0, 0, 0));
      queue_item(mk_req(dst_pkg::OP_EDIT, 0, 9, 9, 99, 16'h0099));
      queue_item(mk_req(dst_pkg::OP_INSERT, 0, 9, 9, 0, 16'h0099));
      wait_table_idle();
      repeat (END_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d requests; table reached %0d of %0d entries.",
               checked_count, accepted_count, peak_fill, DEPTH);
      $display("Statuses: ok %0d, full %0d, empty %0d, bad position %0d, zero date %0d.",
               status_seen[dst_pkg::STAT_OK], status_seen[dst_pkg::STAT_FULL],
               status_seen[dst_pkg::STAT_EMPTY], status_seen[dst_pkg::STAT_BAD_POS],
               status_seen[dst_pkg::STAT_ZERO_DATE]);
      if (mismatch_count == 0) begin
         $display("[deadline_sorted_table] OK");
      end else begin
         $display("[deadline_sorted_table] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[deadline_sorted_table.f]
sv/dst_pkg.sv
sv/dst_cell.sv
sv/dst_gather.sv
sv/deadline_sorted_table.sv
tb/sv/deadline_sorted_table_tb.sv
